### rtl/twt_pkg.sv
// shared constants and handshake structs for the trapped water block
`default_nettype none

package twt_pkg;

    // default storage depth and stored height width
    localparam int MAX_BARS_DEF    = 1024;
    localparam int HEIGHT_BITS_DEF = 16;

    // fixed port widths
    localparam int HEIGHT_IN_BITS = 16;
    localparam int WATER_BITS     = 26;

    localparam logic [WATER_BITS-1:0] WATER_MAX = {WATER_BITS{1'b1}};

    // control from the sequencer to the walk unit
    typedef struct packed {
        logic start;   // load pointers, issue first reads
        logic run;     // perform one walk step
    } walk_ctrl_t;

    // status from the walk unit back to the sequencer
    typedef struct packed {
        logic                  done;   // pointers cross on this step
        logic [WATER_BITS-1:0] total;  // total including this step
    } walk_stat_t;

endpackage

`default_nettype wire

### rtl/twt_bar_mem.sv
// bar height memory: one write port, two registered read ports
`default_nettype none

module twt_bar_mem #(
    parameter int DEPTH  = twt_pkg::MAX_BARS_DEF,
    parameter int ADDR_W = 10,
    parameter int DATA_W = twt_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic      [DATA_W-1:0] rd_data_a,
    output logic      [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

### rtl/twt_walk_core.sv
// two-pointer walk: pointers, running peaks and the water sum
`default_nettype none

module twt_walk_core #(
    parameter int ADDR_W      = 10,
    parameter int HEIGHT_BITS = twt_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire twt_pkg::walk_ctrl_t      ctrl,
    input  wire logic [ADDR_W-1:0]        last_idx,
    input  wire logic [HEIGHT_BITS-1:0]   rd_data_a,
    input  wire logic [HEIGHT_BITS-1:0]   rd_data_b,
    output logic      [ADDR_W-1:0]        rd_addr_a,
    output logic      [ADDR_W-1:0]        rd_addr_b,
    output twt_pkg::walk_stat_t           stat
);

    localparam int ADD_W = ((HEIGHT_BITS > twt_pkg::WATER_BITS) ?
                            HEIGHT_BITS : twt_pkg::WATER_BITS) + 1;

    logic [ADDR_W-1:0]              left_reg, left_next;
    logic [ADDR_W-1:0]              right_reg, right_next;
    logic [HEIGHT_BITS-1:0]         lpeak_reg, lpeak_next;
    logic [HEIGHT_BITS-1:0]         rpeak_reg, rpeak_next;
    logic [HEIGHT_BITS-1:0]         lbar_reg, rbar_reg;
    logic                           lfresh_reg, lfresh_next;
    logic                           rfresh_reg, rfresh_next;
    logic [twt_pkg::WATER_BITS-1:0] sum_reg, sum_next;

    logic [HEIGHT_BITS-1:0] lbar, rbar, diff;
    logic                   step_left, add_en;
    logic [ADD_W-1:0]       sum_wide;

    // current bars: fresh read data for the side that just moved
    assign lbar = lfresh_reg ? rd_data_a : lbar_reg;
    assign rbar = rfresh_reg ? rd_data_b : rbar_reg;

    assign step_left = (lbar <= rbar);

    // read ahead one entry on each side, only the moved side gets used
    assign rd_addr_a = ctrl.start ? '0 : left_reg + ADDR_W'(1);
    assign rd_addr_b = ctrl.start ? last_idx : right_reg - ADDR_W'(1);

    always_comb
    begin
        add_en = 1'b0;
        diff   = '0;
        lpeak_next = lpeak_reg;
        rpeak_next = rpeak_reg;
        if (step_left)
        begin
            if (lpeak_reg <= lbar)
            begin
                lpeak_next = lbar;
            end
            else
            begin
                add_en = 1'b1;
                diff   = lpeak_reg - lbar;
            end
        end
        else
        begin
            if (rpeak_reg <= rbar)
            begin
                rpeak_next = rbar;
            end
            else
            begin
                add_en = 1'b1;
                diff   = rpeak_reg - rbar;
            end
        end
    end

    // saturating accumulate
    assign sum_wide = ADD_W'(sum_reg) + ADD_W'(diff);

    always_comb
    begin
        sum_next = sum_reg;
        if (add_en)
        begin
            if (sum_wide > ADD_W'(twt_pkg::WATER_MAX))
            begin
                sum_next = twt_pkg::WATER_MAX;
            end
            else
            begin
                sum_next = sum_wide[twt_pkg::WATER_BITS-1:0];
            end
        end
    end

    assign left_next   = step_left ? left_reg + ADDR_W'(1) : left_reg;
    assign right_next  = step_left ? right_reg : right_reg - ADDR_W'(1);
    assign lfresh_next = step_left;
    assign rfresh_next = !step_left;

    // a left step with equal pointers is the final one
    assign stat.done  = ctrl.run && step_left && (left_reg == right_reg);
    assign stat.total = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            right_reg  <= '0;
            lpeak_reg  <= '0;
            rpeak_reg  <= '0;
            sum_reg    <= '0;
            lfresh_reg <= 1'b0;
            rfresh_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            left_reg   <= '0;
            right_reg  <= last_idx;
            lpeak_reg  <= '0;
            rpeak_reg  <= '0;
            sum_reg    <= '0;
            lfresh_reg <= 1'b1;
            rfresh_reg <= 1'b1;
        end
        else if (ctrl.run)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            lpeak_reg  <= lpeak_next;
            rpeak_reg  <= rpeak_next;
            sum_reg    <= sum_next;
            lfresh_reg <= lfresh_next;
            rfresh_reg <= rfresh_next;
        end
    end

    // held bars, payload only
    always_ff @(posedge clk)
    begin
        if (ctrl.run)
        begin
            lbar_reg <= lbar;
            rbar_reg <= rbar;
        end
    end

endmodule

`default_nettype wire

### rtl/trapped_water_total.sv
// top level of the trapped water block: load sequencer, store and walk
//
// input channel (in_valid / in_stall): one word per bar, height plus a last
// mark. bars are written into an on-chip memory at one word per cycle; bars
// beyond MAX_BARS are dropped, but a dropped last word still closes the set.
// after the last word the block stalls its input, reads the two ends of the
// store (state S_PRIME) and walks the bars with two pointers, one bar per cycle,
// keeping the next entry on each side read ahead through the memory's two
// read ports. the walk is bound by this one-step-per-cycle memory loop.
// output channel (out_valid / out_stall): one word with the water total per
// set, presented in the cycle after the final walk step and held until the
// receiver takes it; a stall simply holds it and keeps the input stalled.
// the input is stalled during the priming read and the walk.
// reset clears the sequencer, the load count and the output valid; the store
// holds no reset state and its data is only used where the current set wrote it.
`default_nettype none

module trapped_water_total #(
    parameter int MAX_BARS    = twt_pkg::MAX_BARS_DEF,
    parameter int HEIGHT_BITS = twt_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [twt_pkg::HEIGHT_IN_BITS-1:0] height,
    input  wire logic                               last,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [twt_pkg::WATER_BITS-1:0]     water_total
);

    localparam int ADDR_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int CNT_W  = $clog2(MAX_BARS + 1);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_PRIME = 4'b0010,
        S_WALK  = 4'b0100,
        S_SEND  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [ADDR_W-1:0]              last_idx_reg, last_idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic [twt_pkg::WATER_BITS-1:0] total_reg;

    logic                   in_acc;
    logic                   has_room;
    logic                   wr_en;
    logic [HEIGHT_BITS-1:0] bar;
    logic [ADDR_W-1:0]      rd_addr_a, rd_addr_b;
    logic [HEIGHT_BITS-1:0] rd_data_a, rd_data_b;

    twt_pkg::walk_ctrl_t ctrl;
    twt_pkg::walk_stat_t stat;

    // only loading takes input words
    assign in_stall = (state_reg != S_LOAD);
    assign in_acc   = in_valid && !in_stall;

    // keep the low HEIGHT_BITS of the incoming height
    assign bar      = HEIGHT_BITS'(height);
    assign has_room = (count_reg < CNT_W'(MAX_BARS));
    assign wr_en    = in_acc && has_room;

    assign ctrl.start = (state_reg == S_PRIME);
    assign ctrl.run   = (state_reg == S_WALK);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_idx_next  = last_idx_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last)
                    begin
                        // index of the final stored bar
                        last_idx_next = has_room ? count_reg[ADDR_W-1:0]
                                                 : ADDR_W'(MAX_BARS - 1);
                        count_next    = '0;
                        state_next    = S_PRIME;
                    end
                end
            end
            S_PRIME:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (stat.done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_SEND;
                end
            end
            S_SEND:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next     = S_LOAD;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            last_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_idx_reg  <= last_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word, captured on the final walk step
    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            total_reg <= stat.total;
        end
    end

    assign out_valid   = out_valid_reg;
    assign water_total = total_reg;

    twt_bar_mem #(
        .DEPTH  (MAX_BARS),
        .ADDR_W (ADDR_W),
        .DATA_W (HEIGHT_BITS)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (count_reg[ADDR_W-1:0]),
        .wr_data   (bar),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    twt_walk_core #(
        .ADDR_W      (ADDR_W),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .last_idx  (last_idx_reg),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .stat      (stat)
    );

endmodule

`default_nettype wire
